// File: rtl/nsm_pkg.sv
// Shared types, constants and helpers of the NFA state-set matcher.
// Used by nsm_cell, nsm_cell_row and nfa_state_set_matcher_core; no dependencies.
package nsm_pkg;

  localparam int StateCount = 32;
  localparam int SlotCount  = 64;

  localparam int StateIdxW = 5;
  localparam int SlotIdxW  = 6;
  localparam int SymbolW   = 8;
  localparam int CountW    = 7;
  localparam int OpW       = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;

  // Operation codes of an input transaction.
  localparam logic [OpW-1:0] OpLoad    = 2'd0;
  localparam logic [OpW-1:0] OpRestart = 2'd1;
  localparam logic [OpW-1:0] OpAdvance = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegStartState      = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAcceptMask      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTransitionCount = 2'd2;

  typedef logic [StateCount-1:0] state_set_t;

  typedef struct packed {
    logic [StateIdxW-1:0] src;
    logic [StateIdxW-1:0] dst;
    logic [SymbolW-1:0]   sym;
    logic                 eps;
  } edge_t;

  typedef struct packed {
    logic                 en;
    logic [SlotIdxW-1:0]  idx;
    edge_t                entry;
  } load_t;

  typedef struct packed {
    logic                 move_hit;
    logic                 eps_hit;
    logic [StateIdxW-1:0] dst;
  } cell_hit_t;

  function automatic state_set_t state_onehot(input logic [StateIdxW-1:0] s);
    state_set_t v;
    v = '0;
    v[s] = 1'b1;
    return v;
  endfunction

endpackage

// File: rtl/nsm_cell.sv
// One cell of the transition row: holds a single table entry and tests it
// against the broadcast state set and symbol. Depends on nsm_pkg.
module nsm_cell (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  nsm_pkg::edge_t                    entry_i,
  input  logic                              valid_i,
  input  nsm_pkg::state_set_t               set_i,
  input  logic [nsm_pkg::SymbolW-1:0]       symbol_i,
  output nsm_pkg::cell_hit_t                hit_o
);

  nsm_pkg::edge_t entry_q;
  logic           src_active;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      entry_q <= entry_i;
    end
  end

  assign src_active     = valid_i & set_i[entry_q.src];
  assign hit_o.move_hit = src_active & ~entry_q.eps & (entry_q.sym == symbol_i);
  assign hit_o.eps_hit  = src_active & entry_q.eps;
  assign hit_o.dst      = entry_q.dst;

endmodule

// File: rtl/nsm_cell_row.sv
// Row of transition cells with write decode and the OR reduction that forms
// the symbol-move set and the one-step epsilon set. Depends on nsm_pkg, nsm_cell.
module nsm_cell_row (
  input  logic                              clk_i,
  input  nsm_pkg::load_t                    load_i,
  input  logic [nsm_pkg::CountW-1:0]        count_i,
  input  nsm_pkg::state_set_t               set_i,
  input  logic [nsm_pkg::SymbolW-1:0]       symbol_i,
  output nsm_pkg::state_set_t               move_set_o,
  output nsm_pkg::state_set_t               eps_set_o
);

  nsm_pkg::cell_hit_t hits [nsm_pkg::SlotCount];

  logic [nsm_pkg::SlotCount-1:0] move_col [nsm_pkg::StateCount];
  logic [nsm_pkg::SlotCount-1:0] eps_col  [nsm_pkg::StateCount];

  for (genvar c = 0; c < nsm_pkg::SlotCount; c++) begin : g_cell
    logic we;
    logic valid;
    assign we    = load_i.en & (load_i.idx == nsm_pkg::SlotIdxW'(c));
    assign valid = nsm_pkg::CountW'(c) < count_i;

    nsm_cell u_cell (
      .clk_i    (clk_i),
      .we_i     (we),
      .entry_i  (load_i.entry),
      .valid_i  (valid),
      .set_i    (set_i),
      .symbol_i (symbol_i),
      .hit_o    (hits[c])
    );
  end

  // Each state bit is the OR of all cells that hit and point at that state.
  for (genvar s = 0; s < nsm_pkg::StateCount; s++) begin : g_state
    for (genvar c = 0; c < nsm_pkg::SlotCount; c++) begin : g_col
      assign move_col[s][c] = hits[c].move_hit & (hits[c].dst == nsm_pkg::StateIdxW'(s));
      assign eps_col[s][c]  = hits[c].eps_hit  & (hits[c].dst == nsm_pkg::StateIdxW'(s));
    end
    assign move_set_o[s] = |move_col[s];
    assign eps_set_o[s]  = |eps_col[s];
  end

endmodule

// File: rtl/nfa_state_set_matcher_core.sv
// Top level of the NFA state-set matcher: control sequencer, configuration
// registers and output register. Depends on nsm_pkg and nsm_cell_row.
//
// Usage: each input transaction carries an operation. A load writes one
// transition entry into its cell, a restart sets the active set to the epsilon
// closure of the start state, and an advance moves the set over the matching
// symbol transitions and then closes it under epsilon transitions. Every
// transaction returns exactly one result transaction with the active set and
// an accepting flag (active set AND accept mask is nonzero).
// Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i, by the
// user only while no transaction is in progress; the block does not enforce it.
// Sequencing: a load goes straight to the finish state. A restart or advance
// goes through the closure state, which makes one epsilon pass per cycle over
// all 64 cells until a pass adds no state, and then to the finish state. A new
// input is taken only once the result has left the finish state and the
// sequencer is idle again.
// Reset clears the active set, the configuration and all handshake state; the
// cells keep no reset and must be loaded before use. When the receiver
// stalls, a finished result waits in the output register, and the next
// transaction is processed and waits in the finish state until it frees up.
module nfa_state_set_matcher_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               cfg_we_i,
  input  logic [nsm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [nsm_pkg::CfgDataW-1:0]       cfg_wdata_i,

  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [nsm_pkg::OpW-1:0]            operation_i,
  input  logic [nsm_pkg::SlotIdxW-1:0]       entry_index_i,
  input  logic [nsm_pkg::StateIdxW-1:0]      from_state_i,
  input  logic [nsm_pkg::StateIdxW-1:0]      to_state_i,
  input  logic [nsm_pkg::SymbolW-1:0]        symbol_i,
  input  logic                               is_epsilon_i,

  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               accepting_o,
  output logic [nsm_pkg::StateCount-1:0]     active_states_o
);

  // Sequencer states.
  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SClose  = 2'd1;
  localparam logic [1:0] SFinish = 2'd2;

  logic [1:0] state_q, state_d;

  // Configuration registers.
  logic [nsm_pkg::StateIdxW-1:0] start_q, start_d;
  nsm_pkg::state_set_t           accept_mask_q, accept_mask_d;
  logic [nsm_pkg::CountW-1:0]    count_q, count_d;

  // Active state set and output register.
  nsm_pkg::state_set_t set_q, set_d;
  logic                out_valid_q, out_valid_d;
  logic                accepting_q, accepting_d;
  nsm_pkg::state_set_t out_set_q, out_set_d;

  logic                accept;
  logic                finish_fire;
  nsm_pkg::load_t      load;
  nsm_pkg::state_set_t move_set;
  nsm_pkg::state_set_t eps_set;
  nsm_pkg::state_set_t closed_set;

  assign in_ready_o  = (state_q == SIdle);
  assign accept      = in_valid_i & in_ready_o;
  assign finish_fire = (state_q == SFinish) & (~out_valid_q | out_ready_i);

  // A load writes its entry into the addressed cell in the cycle it is accepted.
  assign load.en        = accept & (operation_i == nsm_pkg::OpLoad);
  assign load.idx       = entry_index_i;
  assign load.entry.src = from_state_i;
  assign load.entry.dst = to_state_i;
  assign load.entry.sym = symbol_i;
  assign load.entry.eps = is_epsilon_i;

  nsm_cell_row u_row (
    .clk_i      (clk_i),
    .load_i     (load),
    .count_i    (count_q),
    .set_i      (set_q),
    .symbol_i   (symbol_i),
    .move_set_o (move_set),
    .eps_set_o  (eps_set)
  );

  // One epsilon step widens the set; the closure is done when it stops growing.
  assign closed_set = set_q | eps_set;

  always_comb begin
    state_d = state_q;
    set_d   = set_q;
    case (state_q)
      SIdle: begin
        if (accept) begin
          case (operation_i)
            nsm_pkg::OpRestart: begin
              set_d   = nsm_pkg::state_onehot(start_q);
              state_d = SClose;
            end
            nsm_pkg::OpAdvance: begin
              set_d   = move_set;
              state_d = SClose;
            end
            default: begin
              // Loads and the unused code leave the set as it is.
              state_d = SFinish;
            end
          endcase
        end
      end
      SClose: begin
        set_d = closed_set;
        if (closed_set == set_q) begin
          state_d = SFinish;
        end
      end
      SFinish: begin
        if (finish_fire) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Output register: loaded when a result leaves the finish state.
  always_comb begin
    out_valid_d = out_valid_q;
    accepting_d = accepting_q;
    out_set_d   = out_set_q;
    if (finish_fire) begin
      out_valid_d = 1'b1;
      accepting_d = |(set_q & accept_mask_q);
      out_set_d   = set_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    start_d       = start_q;
    accept_mask_d = accept_mask_q;
    count_d       = count_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        nsm_pkg::RegStartState:      start_d       = cfg_wdata_i[nsm_pkg::StateIdxW-1:0];
        nsm_pkg::RegAcceptMask:      accept_mask_d = cfg_wdata_i[nsm_pkg::StateCount-1:0];
        nsm_pkg::RegTransitionCount: count_d       = cfg_wdata_i[nsm_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SIdle;
      set_q         <= '0;
      out_valid_q   <= 1'b0;
      start_q       <= '0;
      accept_mask_q <= '0;
      count_q       <= '0;
    end else begin
      state_q       <= state_d;
      set_q         <= set_d;
      out_valid_q   <= out_valid_d;
      start_q       <= start_d;
      accept_mask_q <= accept_mask_d;
      count_q       <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    accepting_q <= accepting_d;
    out_set_q   <= out_set_d;
  end

  assign out_valid_o     = out_valid_q;
  assign accepting_o     = accepting_q;
  assign active_states_o = out_set_q;

`ifndef SYNTHESIS
  // The closure loop only ever adds states.
  a_close_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SClose) |=> ((set_q & $past(set_q)) == $past(set_q)))
    else $error("epsilon closure pass dropped an active state");

  // A new result appears only when the sequencer leaves the finish state.
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == SFinish))
    else $error("result presented without a finished transaction");

  // An accepting result must have at least one active state.
  a_accept_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepting_o) |-> (active_states_o != '0))
    else $error("accepting flag set on an empty state set");

  // No input transaction is taken while a closure is running.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SClose) |-> !accept)
    else $error("input accepted during closure");
`endif

endmodule
